[src/msda_pkg.sv]
// Shared types and constants for the mean square displacement accumulator.
// Holds the transfer payload structs, field widths and register codes.
// No dependencies.
package msda_pkg;

    localparam int POS_W  = 32;
    localparam int BOX_W  = 31;
    localparam int SUM_W  = 64;
    localparam int CNT_W  = 11;
    localparam int AXES   = 3;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Remainder unit depth: one sign stage, one stage per magnitude bit, fold and center.
    localparam int MI_LAT = POS_W + 3;

    localparam logic [BOX_W-1:0] BOX_RESET = 31'd655360;

    localparam logic [1:0] REG_BOX_X = 2'd0;
    localparam logic [1:0] REG_BOX_Y = 2'd1;
    localparam logic [1:0] REG_BOX_Z = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic                    last_atom;
    } t_in_item;

    typedef struct packed {
        logic [SUM_W-1:0] msd_sum;
        logic [CNT_W-1:0] atom_count;
        logic             overflow;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic first;
        logic skip;
        logic last;
    } t_ctl;

endpackage

[src/msda_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module msda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/msda_min_image.sv]
// Pipelined minimum-image step for one axis: difference, remainder by the cell length
// one bit per stage, then centering into the half-open range around zero.
// Depends on msda_pkg.
module msda_min_image (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_first,
    input  logic [msda_pkg::POS_W-1:0] i_cur,
    input  logic [msda_pkg::POS_W-1:0] i_prev,
    input  logic [msda_pkg::BOX_W-1:0] i_box,
    output logic [msda_pkg::POS_W-1:0] o_step
);
    import msda_pkg::*;

    localparam int DIV_N = POS_W;
    localparam int SHW   = BOX_W + POS_W;

    logic [POS_W-1:0] r_rem   [0:DIV_N];
    logic [POS_W-1:0] r_val   [0:DIV_N];
    logic             r_neg   [0:DIV_N];
    logic             r_first [0:DIV_N];

    logic [POS_W:0]   n_dpos;
    logic [POS_W:0]   n_dneg;
    logic [POS_W-1:0] n_mag;

    logic [POS_W-1:0] n_fold;
    logic [POS_W-1:0] r_p_r;
    logic [POS_W-1:0] r_p_val;
    logic             r_p_first;

    logic             n_gt;
    logic [POS_W-1:0] n_step;
    logic [POS_W-1:0] r_q_step;

    assign n_dpos = {i_cur[POS_W-1], i_cur} - {i_prev[POS_W-1], i_prev};
    assign n_dneg = {i_prev[POS_W-1], i_prev} - {i_cur[POS_W-1], i_cur};
    assign n_mag  = n_dpos[POS_W] ? n_dneg[POS_W-1:0] : n_dpos[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= n_mag;
            r_val[0]   <= i_first ? i_cur : n_dpos[POS_W-1:0];
            r_neg[0]   <= n_dpos[POS_W];
            r_first[0] <= i_first;
        end
    end

    for (genvar j = 0; j < DIV_N; j++) begin : g_div
        localparam int K = DIV_N - 1 - j;
        logic [SHW-1:0]   w_sh;
        logic             w_ge;
        logic [POS_W-1:0] w_next;

        assign w_sh   = SHW'(i_box) << K;
        assign w_ge   = SHW'(r_rem[j]) >= w_sh;
        assign w_next = w_ge ? (r_rem[j] - w_sh[POS_W-1:0]) : r_rem[j];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]   <= w_next;
                r_val[j+1]   <= r_val[j];
                r_neg[j+1]   <= r_neg[j];
                r_first[j+1] <= r_first[j];
            end
        end
    end

    assign n_fold = (r_neg[DIV_N] && (r_rem[DIV_N] != '0))
                  ? (POS_W'(i_box) - r_rem[DIV_N]) : r_rem[DIV_N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_r     <= n_fold;
            r_p_val   <= r_val[DIV_N];
            r_p_first <= r_first[DIV_N];
        end
    end

    assign n_gt = {r_p_r, 1'b0} > (POS_W + 1)'(i_box);

    always_comb begin
        if ((i_box == '0) || r_p_first) begin
            n_step = r_p_val;
        end else if (n_gt) begin
            n_step = r_p_r - POS_W'(i_box);
        end else begin
            n_step = r_p_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_step <= n_step;
        end
    end

    assign o_step = r_q_step;

endmodule

[src/mean_square_displacement_accumulator_unit.sv]
// Mean square displacement accumulator, top level. Depends on msda_pkg, msda_ram, msda_min_image.
// Throughput: one atom per cycle. The frame result is registered at the output once the
// frame's last atom has passed the pipeline, including the 32-stage remainder pipeline per axis.
// The input stalls only while a frame result at the pipeline tail meets a held output.
// Reset clears control, counters, the sum and the cell lengths (10.0 each); the position
// memories are not cleared and are filled during the first frame.
module mean_square_displacement_accumulator_unit #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  msda_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output msda_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msda_pkg::APB_AW-1:0] paddr,
    input  logic [msda_pkg::APB_DW-1:0] pwdata,
    output logic [msda_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import msda_pkg::*;

    localparam int CW    = $clog2(MAX_ATOMS + 1);
    localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int TAIL  = MI_LAT + 4;
    localparam int RAM_W = AXES * POS_W;

    logic [BOX_W-1:0] r_box_x;
    logic [BOX_W-1:0] r_box_y;
    logic [BOX_W-1:0] r_box_z;
    logic [AXES-1:0][BOX_W-1:0] w_box;

    logic          accept;
    logic          en;
    logic          n_skip;
    logic [CW-1:0] r_cnt;
    logic          r_ref;

    t_ctl          r_ctl [0:TAIL];
    logic [CW-1:0] r_idx [0:TAIL];

    logic [AXES-1:0][POS_W-1:0] w_cur;
    logic [AXES-1:0][POS_W-1:0] r_s1_pos;
    logic [AXES-1:0][POS_W-1:0] w_prev;
    logic [AXES-1:0][POS_W-1:0] w_org;
    logic [AXES-1:0][POS_W-1:0] w_unw;
    logic [AXES-1:0][POS_W-1:0] w_step;

    logic                       r_fwd;
    logic [AXES-1:0][POS_W-1:0] r_fwd_u;
    logic [AXES-1:0][POS_W-1:0] n_uold;
    logic [AXES-1:0][POS_W-1:0] n_unew;
    logic                       unw_we;

    logic [AXES-1:0][POS_W-1:0] r_r_u;
    logic [AXES-1:0][POS_W-1:0] r_r_org;
    logic [AXES-1:0][POS_W:0]   n_diff;
    logic [AXES-1:0][POS_W:0]   n_mag;
    logic [AXES-1:0][POS_W:0]   r_s_mag;
    logic [AXES-1:0][SUM_W-1:0] r_t_sq;
    logic [SUM_W+1:0]           r_u_psum;

    logic [SUM_W-1:0] r_acc;
    logic             r_sat;
    logic [SUM_W+1:0] n_total;
    logic             n_over;
    logic [SUM_W-1:0] n_sum;
    logic             n_sat;
    logic [CW-1:0]    n_count;
    logic [31:0]      n_count32;
    logic             out_load;

    logic      r_out_valid;
    t_out_item r_out_data;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= BOX_RESET;
            r_box_y <= BOX_RESET;
            r_box_z <= BOX_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_BOX_X: r_box_x <= pwdata[BOX_W-1:0];
                REG_BOX_Y: r_box_y <= pwdata[BOX_W-1:0];
                REG_BOX_Z: r_box_z <= pwdata[BOX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BOX_X: prdata = APB_DW'(r_box_x);
            REG_BOX_Y: prdata = APB_DW'(r_box_y);
            REG_BOX_Z: prdata = APB_DW'(r_box_z);
            default:   prdata = '0;
        endcase
    end

    assign w_box = {r_box_z, r_box_y, r_box_x};

    // Handshake and pipeline advance.
    assign en         = !(r_ctl[TAIL].valid && r_ctl[TAIL].last && r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    assign w_cur  = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
    assign n_skip = (r_cnt == CW'(MAX_ATOMS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ref <= 1'b0;
        end else if (accept) begin
            if (i_in_data.last_atom) begin
                r_cnt <= '0;
                r_ref <= 1'b1;
            end else if (!n_skip) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= TAIL; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (en) begin
            r_ctl[0].valid <= accept;
            r_ctl[0].first <= !r_ref;
            r_ctl[0].skip  <= n_skip;
            r_ctl[0].last  <= i_in_data.last_atom;
            for (int k = 1; k <= TAIL; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx[0] <= r_cnt;
            for (int k = 1; k <= TAIL; k++) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
        if (accept) begin
            r_s1_pos <= w_cur;
        end
    end

    // Per-atom position stores.
    msda_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ATOMS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !n_skip),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_cur),
        .i_re    (accept),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (w_prev)
    );

    msda_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ATOMS)) u_origin_ram (
        .i_clk   (i_clk),
        .i_we    (accept && !n_skip && !r_ref),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_cur),
        .i_re    (en),
        .i_raddr (r_idx[MI_LAT-1][AW-1:0]),
        .o_rdata (w_org)
    );

    msda_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ATOMS)) u_unwrap_ram (
        .i_clk   (i_clk),
        .i_we    (unw_we),
        .i_waddr (r_idx[MI_LAT][AW-1:0]),
        .i_wdata (n_unew),
        .i_re    (en),
        .i_raddr (r_idx[MI_LAT-1][AW-1:0]),
        .o_rdata (w_unw)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        msda_min_image u_min_image (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_first (r_ctl[0].first),
            .i_cur   (r_s1_pos[a]),
            .i_prev  (w_prev[a]),
            .i_box   (w_box[a]),
            .o_step  (w_step[a])
        );
    end

    // Unwrapped update, with forwarding when the same atom was written in the previous cycle.
    assign unw_we = en && r_ctl[MI_LAT].valid && !r_ctl[MI_LAT].skip;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_uold[a] = r_fwd ? r_fwd_u[a] : w_unw[a];
            n_unew[a] = r_ctl[MI_LAT].first ? w_step[a] : (n_uold[a] + w_step[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (en) begin
            r_fwd <= r_ctl[MI_LAT].valid && !r_ctl[MI_LAT].skip
                     && (r_idx[MI_LAT] == r_idx[MI_LAT-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (unw_we) begin
            r_fwd_u <= n_unew;
        end
    end

    // Displacement, square and frame sum.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_diff[a] = {r_r_u[a][POS_W-1], r_r_u[a]} - {r_r_org[a][POS_W-1], r_r_org[a]};
            n_mag[a]  = n_diff[a][POS_W] ? ((POS_W + 1)'(0) - n_diff[a]) : n_diff[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_u   <= n_unew;
            r_r_org <= w_org;
            r_s_mag <= n_mag;
            for (int a = 0; a < AXES; a++) begin
                r_t_sq[a] <= r_s_mag[a][POS_W] ? '0
                           : (SUM_W'(r_s_mag[a][POS_W-1:0]) * SUM_W'(r_s_mag[a][POS_W-1:0]));
            end
            if (r_ctl[TAIL-1].first || r_ctl[TAIL-1].skip) begin
                r_u_psum <= '0;
            end else begin
                r_u_psum <= (SUM_W + 2)'(r_t_sq[0]) + (SUM_W + 2)'(r_t_sq[1])
                          + (SUM_W + 2)'(r_t_sq[2]);
            end
        end
    end

    assign n_total   = (SUM_W + 2)'(r_acc) + r_u_psum;
    assign n_over    = |n_total[SUM_W+1:SUM_W];
    assign n_sum     = n_over ? '1 : n_total[SUM_W-1:0];
    assign n_sat     = r_sat || n_over;
    assign n_count   = r_ctl[TAIL].skip ? CW'(MAX_ATOMS) : (r_idx[TAIL] + CW'(1));
    assign n_count32 = 32'(n_count);
    assign out_load  = en && r_ctl[TAIL].valid && r_ctl[TAIL].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (en && r_ctl[TAIL].valid) begin
            if (r_ctl[TAIL].last) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                r_acc <= n_sum;
                r_sat <= n_sat;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.msd_sum    <= n_sum;
            r_out_data.atom_count <= n_count32[CNT_W-1:0];
            r_out_data.overflow   <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ATOMS))
        else $error("Atom index exceeds the atom limit.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("A frame result overwrote a result still waiting for transfer.");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last_atom) |=> ((r_cnt == '0) && r_ref))
        else $error("The atom index did not restart after the last atom of a frame.");

endmodule

[sim/mean_square_displacement_accumulator_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for mean_square_displacement_accumulator_unit.
// It streams atom frames with random pacing and checks each frame result against a local
// prediction. Depends on msda_pkg and the accumulator RTL.
module mean_square_displacement_accumulator_unit_test;
    import msda_pkg::*;

    localparam int ATOM_CAP = 1024;
    localparam int QUIET_LIMIT = 2000;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [POS_W-1:0] HALF_CELL = 32'sd327680;
    localparam logic signed [POS_W-1:0] FULL_CELL = 32'sd655360;
    localparam logic [BOX_W-1:0] LEN_MAX = 31'h7fff_ffff;

    typedef struct {
        t_in_item    atom;
        int unsigned idle;
    } t_paced_atom;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    t_paced_atom atoms_to_send[$];
    t_paced_atom next_atom;
    t_out_item   frame_sums_due[$];
    t_out_item   want;
    logic        in_accepted = 1'b0;
    logic        out_accepted = 1'b0;
    int unsigned send_idle = 0;
    int unsigned send_calm = 0;
    int unsigned take_hold = 0;
    int unsigned take_calm = 0;
    logic        take_armed = 1'b0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;
    int          atoms_taken = 0;
    int          frames_checked = 0;
    int          queued_total = 0;
    int          settings_used = 1;

    // Local copy of the cell lengths and the per-atom trajectory state.
    logic [BOX_W-1:0]        cell_len [AXES] = '{BOX_RESET, BOX_RESET, BOX_RESET};
    logic                    have_origin = 1'b0;
    int                      atom_slot = 0;
    logic [SUM_W-1:0]        frame_sum = '0;
    logic                    frame_sat = 1'b0;
    logic signed [POS_W-1:0] seen_pos [ATOM_CAP][AXES];
    logic signed [POS_W-1:0] travel_pos [ATOM_CAP][AXES];
    logic signed [POS_W-1:0] start_pos [ATOM_CAP][AXES];
    logic signed [POS_W-1:0] walk_pos [ATOM_CAP][AXES];

    mean_square_displacement_accumulator_unit #(
        .MAX_ATOMS(ATOM_CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic track_atom(input t_in_item a);
        logic signed [POS_W-1:0] here [AXES];
        longint                  stride;
        longint                  span;
        longint                  offset;
        longint unsigned         mag;
        longint unsigned         total;
        t_out_item               done;
        here[0] = a.pos_x;
        here[1] = a.pos_y;
        here[2] = a.pos_z;
        if (atom_slot < ATOM_CAP) begin
            for (int k = 0; k < AXES; k++) begin
                if (!have_origin) begin
                    seen_pos[atom_slot][k] = here[k];
                    travel_pos[atom_slot][k] = here[k];
                    start_pos[atom_slot][k] = here[k];
                end else begin
                    stride = longint'(here[k]) - longint'(seen_pos[atom_slot][k]);
                    span = longint'(cell_len[k]);
                    if (span != 0) begin
                        stride = stride % span;
                        if (stride < 0) begin
                            stride += span;
                        end
                        if (2 * stride > span) begin
                            stride -= span;
                        end
                    end
                    travel_pos[atom_slot][k] += stride[POS_W-1:0];
                    seen_pos[atom_slot][k] = here[k];
                    offset = longint'(travel_pos[atom_slot][k])
                        - longint'(start_pos[atom_slot][k]);
                    mag = (offset < 0) ? -offset : offset;
                    total = frame_sum + mag * mag;
                    if (total < frame_sum) begin
                        frame_sum = '1;
                        frame_sat = 1'b1;
                    end else begin
                        frame_sum = total;
                    end
                end
            end
            atom_slot++;
        end
        if (a.last_atom) begin
            done.msd_sum = frame_sum;
            done.atom_count = atom_slot[CNT_W-1:0];
            done.overflow = frame_sat;
            frame_sums_due.push_back(done);
            have_origin = 1'b1;
            atom_slot = 0;
            frame_sum = '0;
            frame_sat = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
            out_accepted <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_accepted <= i_in_valid && !o_in_stall;
            out_accepted <= o_out_valid && !i_out_stall;
            if (i_in_valid && !o_in_stall) begin
                atoms_taken++;
                track_atom(i_in_data);
            end
            if (o_out_valid && !i_out_stall) begin
                frames_checked++;
                if (frame_sums_due.size() == 0) begin
                    note_mismatch($sformatf("frame result %0d arrived with nothing pending",
                        frames_checked));
                end else begin
                    want = frame_sums_due.pop_front();
                    if (o_out_data.msd_sum !== want.msd_sum) begin
                        note_mismatch($sformatf("frame %0d msd_sum %h, predicted %h",
                            frames_checked, o_out_data.msd_sum, want.msd_sum));
                    end
                    if (o_out_data.atom_count !== want.atom_count) begin
                        note_mismatch($sformatf("frame %0d atom_count %0d, predicted %0d",
                            frames_checked, o_out_data.atom_count, want.atom_count));
                    end
                    if (o_out_data.overflow !== want.overflow) begin
                        note_mismatch($sformatf("frame %0d overflow %b, predicted %b",
                            frames_checked, o_out_data.overflow, want.overflow));
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Input driver: a new atom goes out only after the previous transfer.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_accepted)) begin
            if (send_idle > 0) begin
                i_in_valid <= 1'b0;
                send_idle--;
            end else if (atoms_to_send.size() != 0) begin
                next_atom = atoms_to_send.pop_front();
                i_in_data <= next_atom.atom;
                i_in_valid <= 1'b1;
                send_idle = next_atom.idle;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result side: each frame result is held off for a freshly drawn number of cycles, or not at all in calm spells.
    always @(negedge i_clk) begin
        if (out_accepted) begin
            take_armed = 1'b0;
        end
        if (o_out_valid === 1'b1 && !take_armed) begin
            take_armed = 1'b1;
            if (take_calm > 0) begin
                take_calm--;
                take_hold = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) begin
                    take_calm = $urandom_range(5, 20);
                end
                take_hold = $urandom_range(0, 15);
            end
        end
        if (take_armed) begin
            i_out_stall <= (take_hold > 0);
            if (take_hold > 0) begin
                take_hold--;
            end
        end else begin
            i_out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic apb_access(input logic [1:0] code, input logic write_en,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write_en;
        paddr <= {code, 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_cell(input logic [1:0] code);
        logic [APB_DW-1:0] readback;
        apb_access(code, 1'b0, '0, readback);
        if (readback !== {1'b0, cell_len[code]}) begin
            note_mismatch($sformatf("cell register %0d reads %h, predicted %h",
                code, readback, {1'b0, cell_len[code]}));
        end
    endtask

    task automatic set_cell(input logic [1:0] code, input logic [BOX_W-1:0] len);
        logic [APB_DW-1:0] unused;
        apb_access(code, 1'b1, {1'b0, len}, unused);
        cell_len[code] = len;
        check_cell(code);
    endtask

    task automatic queue_atom(input int idx, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic signed [POS_W-1:0] z, input logic last);
        t_paced_atom entry;
        entry.atom.pos_x = x;
        entry.atom.pos_y = y;
        entry.atom.pos_z = z;
        entry.atom.last_atom = last;
        if (send_calm > 0) begin
            send_calm--;
            entry.idle = 0;
        end else begin
            if ($urandom_range(0, 15) == 0) begin
                send_calm = $urandom_range(10, 40);
            end
            entry.idle = $urandom_range(0, 15);
        end
        atoms_to_send.push_back(entry);
        queued_total++;
        if (idx < ATOM_CAP) begin
            walk_pos[idx][0] = x;
            walk_pos[idx][1] = y;
            walk_pos[idx][2] = z;
        end
    endtask

    // Atoms move by random steps inside the cell and are wrapped back into it;
    // noisy frames and some coordinates jump anywhere in the full range.
    task automatic queue_frame(input int from, input int count, input logic noisy);
        logic signed [POS_W-1:0] c [AXES];
        longint                  span;
        longint                  spot;
        int unsigned             reach;
        for (int i = from; i < count; i++) begin
            for (int k = 0; k < AXES; k++) begin
                span = longint'(cell_len[k]);
                if (i >= ATOM_CAP || span == 0 || noisy || $urandom_range(0, 15) == 0) begin
                    c[k] = $urandom;
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            reach = 16;
                        end
                        1: begin
                            reach = 32'(span / 16);
                        end
                        2: begin
                            reach = 32'(span / 2);
                        end
                        default: begin
                            reach = 32'(span);
                        end
                    endcase
                    spot = longint'(walk_pos[i][k]) + longint'($urandom_range(0, 2 * reach))
                        - longint'(reach);
                    spot = spot % span;
                    if (spot < 0) begin
                        spot += span;
                    end
                    c[k] = spot[POS_W-1:0];
                end
            end
            queue_atom(i, c[0], c[1], c[2], i == count - 1);
        end
    endtask

    task automatic settle();
        while (atoms_to_send.size() != 0 || i_in_valid || frame_sums_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (50) @(negedge i_clk);
    endtask

    function automatic logic [BOX_W-1:0] pick_len();
        case ($urandom_range(0, 5))
            0: begin
                return LEN_MAX;
            end
            1: begin
                return 31'd1;
            end
            2: begin
                return BOX_W'($urandom_range(1, 16));
            end
            3: begin
                return BOX_W'($urandom_range(65536, 50 * 65536));
            end
            4: begin
                return BOX_W'($urandom_range(1, 32'h7fff_ffff));
            end
            default: begin
                return BOX_RESET;
            end
        endcase
    endfunction

    initial begin
        int phase_start;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_cell(REG_BOX_X);
        check_cell(REG_BOX_Y);
        check_cell(REG_BOX_Z);

        // Reference frame with extreme origins up front; no later frame is longer.
        queue_atom(0, POS_MIN, POS_MIN, POS_MIN, 1'b0);
        queue_atom(1, POS_MAX, POS_MAX, POS_MAX, 1'b0);
        queue_atom(2, '0, '0, '0, 1'b0);
        queue_atom(3, -32'sd1, -32'sd1, -32'sd1, 1'b0);
        queue_frame(4, 64, 1'b0);

        // Half-cell steps in both directions, a whole-cell step and a one-atom frame.
        queue_atom(0, POS_MIN, POS_MIN, POS_MIN, 1'b0);
        queue_atom(1, POS_MAX, POS_MAX, POS_MAX, 1'b0);
        queue_atom(2, HALF_CELL, -HALF_CELL, FULL_CELL, 1'b0);
        queue_atom(3, '0, 32'sd1, POS_MIN, 1'b1);
        queue_atom(0, POS_MIN + 32'sd1, '0, POS_MAX, 1'b1);

        // Zero cell length: plain differences, unwrapped wrap-around and a saturated sum.
        settle();
        set_cell(REG_BOX_X, '0);
        set_cell(REG_BOX_Y, '0);
        set_cell(REG_BOX_Z, '0);
        settings_used++;
        queue_atom(0, POS_MAX, POS_MAX, POS_MAX, 1'b0);
        queue_atom(1, POS_MIN, POS_MIN, POS_MIN, 1'b1);
        queue_atom(0, '0, '0, '0, 1'b1);

        settle();
        set_cell(REG_BOX_X, 31'd1);
        set_cell(REG_BOX_Y, LEN_MAX);
        set_cell(REG_BOX_Z, BOX_RESET);
        settings_used++;
        queue_frame(0, 3, 1'b1);

        for (int p = 0; p < 5; p++) begin
            settle();
            set_cell(REG_BOX_X, pick_len());
            set_cell(REG_BOX_Y, pick_len());
            set_cell(REG_BOX_Z, pick_len());
            settings_used++;
            phase_start = queued_total;
            while (queued_total - phase_start < 110) begin
                queue_frame(0, ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                          : $urandom_range(1, 12),
                            $urandom_range(0, 7) == 0);
            end
        end
        settle();

        $display("Run covered %0d atom transfers and %0d frame results over %0d cell settings.",
            atoms_taken, frames_checked, settings_used);
        $display("It included zero and extreme cell lengths, half-cell steps, %s",
            "coordinate wrap-around and a saturated sum.");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
src/msda_pkg.sv
src/msda_ram.sv
src/msda_min_image.sv
src/mean_square_displacement_accumulator_unit.sv
sim/mean_square_displacement_accumulator_unit_test.sv
